// ===== hw/rtl/scd_pkg.sv =====
// shared types and constants for the serial CAN frame deframer
package scd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam int unsigned ID_BYTES = 4;
    localparam int unsigned PAYLOAD_W = 64;

    typedef enum logic [5:0] {
        PH_SYNC  = 6'b000001,
        PH_FLAGS = 6'b000010,
        PH_ID    = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [31:0]          frame_id;
        logic                 extended_id;
        logic [3:0]           length;
        logic [PAYLOAD_W-1:0] payload;
    } frame_t;

endpackage

// ===== hw/rtl/scd_parse.sv =====
// byte-wise frame parser: sync hunt, field capture, checksum and frame build
module scd_parse #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            take,
    input  logic [7:0]      rx_byte,
    output logic            fire,
    output scd_pkg::frame_t frame
);

    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    scd_pkg::phase_t phase_reg, phase_next;
    logic        ext_reg, ext_next;
    logic [31:0] id_reg, id_next;
    logic [1:0]  id_cnt_reg, id_cnt_next;
    logic [3:0]  len_reg, len_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  store_reg [MAX_PAYLOAD];
    logic        store_we;
    logic [3:0]  dcnt_inc;

    assign dcnt_inc = dcnt_reg + 4'd1;

    always_comb begin
        phase_next  = phase_reg;
        ext_next    = ext_reg;
        id_next     = id_reg;
        id_cnt_next = id_cnt_reg;
        len_next    = len_reg;
        dcnt_next   = dcnt_reg;
        xor_next    = xor_reg;
        store_we    = 1'b0;
        fire        = 1'b0;
        unique case (phase_reg)
            scd_pkg::PH_FLAGS: begin
                ext_next    = rx_byte[0];
                xor_next    = xor_reg ^ rx_byte;
                id_next     = '0;
                id_cnt_next = '0;
                phase_next  = scd_pkg::PH_ID;
            end
            scd_pkg::PH_ID: begin
                id_next  = id_reg | ({24'd0, rx_byte} << {id_cnt_reg, 3'b000});
                xor_next = xor_reg ^ rx_byte;
                id_cnt_next = id_cnt_reg + 2'd1;
                if (id_cnt_reg == 2'(scd_pkg::ID_BYTES - 1)) begin
                    phase_next = scd_pkg::PH_LEN;
                end
            end
            scd_pkg::PH_LEN: begin
                if (rx_byte > 8'(MAX_PAYLOAD)) begin
                    phase_next = scd_pkg::PH_SYNC;
                end else begin
                    len_next   = rx_byte[3:0];
                    xor_next   = xor_reg ^ rx_byte;
                    dcnt_next  = '0;
                    phase_next = (rx_byte[3:0] == 4'd0) ? scd_pkg::PH_CHECK
                                                         : scd_pkg::PH_DATA;
                end
            end
            scd_pkg::PH_DATA: begin
                store_we  = 1'b1;
                xor_next  = xor_reg ^ rx_byte;
                dcnt_next = dcnt_inc;
                if (dcnt_inc >= len_reg) begin
                    phase_next = scd_pkg::PH_CHECK;
                end
            end
            scd_pkg::PH_CHECK: begin
                phase_next = scd_pkg::PH_SYNC;
                fire       = (rx_byte == xor_reg);
            end
            default: begin
                // sync hunt, also recovers from illegal phase codes
                phase_next = scd_pkg::PH_SYNC;
                if (rx_byte == scd_pkg::SYNC_BYTE) begin
                    phase_next = scd_pkg::PH_FLAGS;
                    xor_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= scd_pkg::PH_SYNC;
            ext_reg    <= 1'b0;
            id_reg     <= '0;
            id_cnt_reg <= '0;
            len_reg    <= '0;
            dcnt_reg   <= '0;
            xor_reg    <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            ext_reg    <= ext_next;
            id_reg     <= id_next;
            id_cnt_reg <= id_cnt_next;
            len_reg    <= len_next;
            dcnt_reg   <= dcnt_next;
            xor_reg    <= xor_next;
        end
    end

    // payload bytes, only entries written in the current frame are read
    always_ff @(posedge aclk) begin
        if (take && store_we) begin
            store_reg[dcnt_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    always_comb begin
        frame.frame_id    = id_reg;
        frame.extended_id = ext_reg;
        frame.length      = len_reg;
        frame.payload     = '0;
        for (int i = 0; i < MAX_PAYLOAD; i++) begin
            if (4'(i) < len_reg) begin
                frame.payload[8*i +: 8] = store_reg[i];
            end
        end
    end

endmodule

// ===== hw/rtl/serial_can_frame_deframer.sv =====
// serial CAN frame deframer: one byte per request in, one frame per good checksum out
// a frame appears on m_ in the cycle after its checksum byte is accepted
// throughput: one byte per cycle; s_ready drops only while a finished frame waits
// for m_ready, since the single output register holds one frame
// reset (aresetn low, synchronous) returns to sync hunt and empties the output
module serial_can_frame_deframer #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_frame_id,
    output logic        m_extended_id,
    output logic [3:0]  m_length,
    output logic [63:0] m_payload
);

    logic            take;
    logic            fire;
    scd_pkg::frame_t frame;
    scd_pkg::frame_t out_reg;
    logic            out_valid_reg, out_valid_next;

    assign s_ready = !out_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    scd_parse #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .rx_byte (s_rx_byte),
        .fire    (fire),
        .frame   (frame)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (take && fire) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && fire) begin
            out_reg <= frame;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_frame_id    = out_reg.frame_id;
    assign m_extended_id = out_reg.extended_id;
    assign m_length      = out_reg.length;
    assign m_payload     = out_reg.payload;

endmodule
